/* rtl/plmf_pkg.sv */
package plmf_pkg;

    // Default pool size and fixed field widths
    localparam int PLMF_POOL_NODES = 16;
    localparam int ID_W            = 20;
    localparam int GRADE_W         = 16;
    localparam int STATUS_W        = 2;
    localparam int SLOT_W          = 4;
    localparam int AFTER_W         = 4;

    // Tie stack: ids collected by a report
    localparam int TIE_DEPTH = 16;
    localparam int TIE_IW    = $clog2(TIE_DEPTH);
    localparam int TIE_CW    = $clog2(TIE_DEPTH + 1);

    // Command codes
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REPORT = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_POOL_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_MIN_ENTRY = 2'd3;

    // Controller to datapath commands
    typedef struct packed {
        logic cap_in;
        logic ins_rd;
        logic ins_wr1;
        logic ins_wr2;
        logic walk_start;
        logic walk_rd;
        logic walk_ev;
        logic emit_ins;
        logic emit_full;
        logic emit_empty;
        logic emit_tie;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic pool_full;
        logic list_empty;
        logic use_pred;
        logic walk_done;
        logic tie_one;
    } t_dp_sts;

endpackage

/* rtl/pooled_linked_list_min_finder.sv */
// Pooled linked list with minimum-grade report.
// A transaction is accepted on a rising edge with start high and busy low.
// i_cmd selects insert (store i_item_id / i_item_grade in the node at the
// head of the free chain, linked at the list head or after i_after_index
// when that node is in the list) or report (walk the list, return every id
// holding the lowest grade, at most TIE_DEPTH of them, last one marked by o_last).
// Results appear on the o_ ports for exactly one cycle with o_valid high;
// the receiver cannot hold them off, so each must be taken when shown.
// An insert reads the free-chain head, writes the new node, then (when linked
// after a predecessor) does a second link-store write to it, then strobes its
// result. A pool-full insert or an empty report strobes its result directly.
// A report walks the list (registered link-store read, then compare, for each
// node), then emits one result per cycle from the tie stack. busy is high
// until the last result is issued; one transaction is worked on at a time.
// Reset (synchronous, active low) empties the list and chains every node
// into the free pool in index order; no clearing pass is needed.
module pooled_linked_list_min_finder
    import plmf_pkg::*;
#(
    parameter int POOL_NODES = PLMF_POOL_NODES
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       i_cmd,
    input  logic [ID_W-1:0]            i_item_id,
    input  logic signed [GRADE_W-1:0]  i_item_grade,
    input  logic                       i_after_valid,
    input  logic [AFTER_W-1:0]         i_after_index,
    output logic                       o_valid,
    output logic [STATUS_W-1:0]        o_status,
    output logic [SLOT_W-1:0]          o_slot_index,
    output logic [ID_W-1:0]            o_min_id,
    output logic signed [GRADE_W-1:0]  o_min_grade,
    output logic                       o_last,
    output logic                       o_list_empty,
    output logic                       o_pool_full
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    // Sequencer
    plmf_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_cmd    (i_cmd),
        .i_sts    (dp_sts),
        .o_dp_cmd (dp_cmd),
        .busy     (busy)
    );

    // Node pool, walk and result registers
    plmf_dpath #(
        .POOL_NODES (POOL_NODES)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_dp_cmd      (dp_cmd),
        .i_item_id     (i_item_id),
        .i_item_grade  (i_item_grade),
        .i_after_valid (i_after_valid),
        .i_after_index (i_after_index),
        .o_sts         (dp_sts),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_slot_index  (o_slot_index),
        .o_min_id      (o_min_id),
        .o_min_grade   (o_min_grade),
        .o_last        (o_last),
        .o_list_empty  (o_list_empty),
        .o_pool_full   (o_pool_full)
    );

endmodule

/* rtl/plmf_ctrl.sv */
module plmf_ctrl
    import plmf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  logic    i_cmd,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_dp_cmd,
    output logic    busy
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_WR1,
        S_INS_WR2,
        S_INS_EMIT,
        S_FULL_EMIT,
        S_EMPTY_EMIT,
        S_WALK_RD,
        S_WALK_EV,
        S_TIE_EMIT
    } t_state;

    t_state  r_state;
    t_state  n_state;
    logic    r_busy;
    t_dp_cmd dp_cmd;

    // Next state and datapath commands
    always_comb begin
        n_state = r_state;
        dp_cmd  = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    dp_cmd.cap_in = 1'b1;
                    if (i_cmd == CMD_REPORT) begin
                        if (i_sts.list_empty) begin
                            n_state = S_EMPTY_EMIT;
                        end else begin
                            dp_cmd.walk_start = 1'b1;
                            n_state           = S_WALK_RD;
                        end
                    end else begin
                        n_state = S_INS_RD;
                    end
                end
            end
            S_INS_RD: begin
                if (i_sts.pool_full) begin
                    n_state = S_FULL_EMIT;
                end else begin
                    dp_cmd.ins_rd = 1'b1;
                    n_state       = S_INS_WR1;
                end
            end
            S_INS_WR1: begin
                dp_cmd.ins_wr1 = 1'b1;
                n_state        = i_sts.use_pred ? S_INS_WR2 : S_INS_EMIT;
            end
            S_INS_WR2: begin
                dp_cmd.ins_wr2 = 1'b1;
                n_state        = S_INS_EMIT;
            end
            S_INS_EMIT: begin
                dp_cmd.emit_ins = 1'b1;
                n_state         = S_IDLE;
            end
            S_FULL_EMIT: begin
                dp_cmd.emit_full = 1'b1;
                n_state          = S_IDLE;
            end
            S_EMPTY_EMIT: begin
                dp_cmd.emit_empty = 1'b1;
                n_state           = S_IDLE;
            end
            S_WALK_RD: begin
                if (i_sts.walk_done) begin
                    n_state = S_TIE_EMIT;
                end else begin
                    dp_cmd.walk_rd = 1'b1;
                    n_state        = S_WALK_EV;
                end
            end
            S_WALK_EV: begin
                dp_cmd.walk_ev = 1'b1;
                n_state        = S_WALK_RD;
            end
            S_TIE_EMIT: begin
                dp_cmd.emit_tie = 1'b1;
                if (i_sts.tie_one) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and busy flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
        end
    end

    assign o_dp_cmd = dp_cmd;
    assign busy     = r_busy;

endmodule

/* rtl/plmf_dpath.sv */
module plmf_dpath
    import plmf_pkg::*;
#(
    parameter int POOL_NODES = PLMF_POOL_NODES
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_dp_cmd                    i_dp_cmd,
    input  logic [ID_W-1:0]            i_item_id,
    input  logic signed [GRADE_W-1:0]  i_item_grade,
    input  logic                       i_after_valid,
    input  logic [AFTER_W-1:0]         i_after_index,
    output t_dp_sts                    o_sts,
    output logic                       o_valid,
    output logic [STATUS_W-1:0]        o_status,
    output logic [SLOT_W-1:0]          o_slot_index,
    output logic [ID_W-1:0]            o_min_id,
    output logic signed [GRADE_W-1:0]  o_min_grade,
    output logic                       o_last,
    output logic                       o_list_empty,
    output logic                       o_pool_full
);

    // Node index and link widths; a link holds POOL_NODES as nil
    localparam int IW = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
    localparam int LW = $clog2(POOL_NODES + 1);
    localparam logic [LW-1:0] NIL = LW'(POOL_NODES);

    // Node pool storage
    logic [LW-1:0]             link_mem  [POOL_NODES];
    logic [ID_W-1:0]           id_mem    [POOL_NODES];
    logic signed [GRADE_W-1:0] grade_mem [POOL_NODES];
    logic [POOL_NODES-1:0]     r_link_vld;
    logic [POOL_NODES-1:0]     r_in_list;

    // Tie stack
    logic [ID_W-1:0]           tie_mem [TIE_DEPTH];
    logic [TIE_CW-1:0]         r_tie_cnt;

    // List control registers
    logic [LW-1:0]             r_list_head;
    logic [LW-1:0]             r_free_head;
    logic [IW-1:0]             r_taken;
    logic [LW-1:0]             r_cur;
    logic [LW-1:0]             r_steps;
    logic                      r_first;
    logic signed [GRADE_W-1:0] r_min;

    // Captured transaction fields
    logic [ID_W-1:0]           r_in_id;
    logic signed [GRADE_W-1:0] r_in_grade;
    logic                      r_after_valid;
    logic [AFTER_W-1:0]        r_after_index;

    // Registered memory reads
    logic [LW-1:0]             r_rd_link_a;
    logic                      r_rd_vld_a;
    logic [IW-1:0]             r_rd_addr_a;
    logic [ID_W-1:0]           r_rd_id;
    logic signed [GRADE_W-1:0] r_rd_grade;
    logic [LW-1:0]             r_rd_link_b;
    logic                      r_rd_vld_b;
    logic [IW-1:0]             r_rd_addr_b;

    // Result registers
    logic                      r_valid;
    logic [STATUS_W-1:0]       r_status;
    logic [SLOT_W-1:0]         r_slot;
    logic [ID_W-1:0]           r_out_id;
    logic signed [GRADE_W-1:0] r_out_grade;
    logic                      r_last;
    logic                      r_list_empty;
    logic                      r_pool_full;

    logic [IW+AFTER_W-1:0]     pred_ext;
    logic [IW-1:0]             pred_idx;
    logic                      use_pred;
    logic [IW-1:0]             rd_addr_a;
    logic [LW-1:0]             link_a;
    logic [LW-1:0]             link_b;
    logic                      mem_we;
    logic [IW-1:0]             mem_waddr;
    logic [LW-1:0]             mem_wdata;
    logic [IW+SLOT_W-1:0]      taken_ext;
    logic                      list_is_empty;
    logic                      pool_is_full;
    logic                      walk_done;
    logic [TIE_CW-1:0]         tie_top;

    // Predecessor decode: index must be in range and name a listed node
    assign pred_ext = {{IW{1'b0}}, r_after_index};
    assign pred_idx = pred_ext[IW-1:0];
    assign use_pred = r_after_valid
                   && (pred_ext < (IW+AFTER_W)'(POOL_NODES))
                   && r_in_list[pred_idx];

    assign list_is_empty = (r_list_head >= NIL);
    assign pool_is_full  = (r_free_head >= NIL);
    assign walk_done     = (r_cur >= NIL) || (r_steps == NIL);
    assign tie_top       = r_tie_cnt - TIE_CW'(1);
    assign taken_ext     = {{SLOT_W{1'b0}}, r_taken};

    // Read port A follows the walk or the free head; port B the predecessor
    assign rd_addr_a = i_dp_cmd.walk_rd ? r_cur[IW-1:0] : r_free_head[IW-1:0];

    // A link never written reads as its reset value, the next index
    assign link_a = r_rd_vld_a ? r_rd_link_a : (LW'(r_rd_addr_a) + LW'(1));
    assign link_b = r_rd_vld_b ? r_rd_link_b : (LW'(r_rd_addr_b) + LW'(1));

    // Link write port: new node first, then the predecessor
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_taken;
        mem_wdata = r_list_head;
        if (i_dp_cmd.ins_wr1) begin
            mem_we    = 1'b1;
            mem_wdata = use_pred ? link_b : r_list_head;
        end else if (i_dp_cmd.ins_wr2) begin
            mem_we    = 1'b1;
            mem_waddr = pred_idx;
            mem_wdata = LW'(r_taken);
        end
    end

    // Node pool memories
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            link_mem[mem_waddr] <= mem_wdata;
        end
        if (i_dp_cmd.ins_wr1) begin
            id_mem[r_taken]    <= r_in_id;
            grade_mem[r_taken] <= r_in_grade;
        end
        r_rd_link_a <= link_mem[rd_addr_a];
        r_rd_id     <= id_mem[rd_addr_a];
        r_rd_grade  <= grade_mem[rd_addr_a];
        r_rd_link_b <= link_mem[pred_idx];
        r_rd_vld_a  <= r_link_vld[rd_addr_a];
        r_rd_vld_b  <= r_link_vld[pred_idx];
        r_rd_addr_a <= rd_addr_a;
        r_rd_addr_b <= pred_idx;
    end

    // Link valid and list membership bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link_vld <= '0;
            r_in_list  <= '0;
        end else begin
            if (mem_we) begin
                r_link_vld[mem_waddr] <= 1'b1;
            end
            if (i_dp_cmd.ins_wr1) begin
                r_in_list[r_taken] <= 1'b1;
            end
        end
    end

    // Transaction capture
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.cap_in) begin
            r_in_id       <= i_item_id;
            r_in_grade    <= i_item_grade;
            r_after_valid <= i_after_valid;
            r_after_index <= i_after_index;
        end
        if (i_dp_cmd.ins_rd) begin
            r_taken <= r_free_head[IW-1:0];
        end
    end

    // Heads, walk and minimum tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_list_head <= NIL;
            r_free_head <= '0;
            r_tie_cnt   <= '0;
            r_min       <= '0;
            r_cur       <= NIL;
            r_steps     <= '0;
            r_first     <= 1'b0;
        end else begin
            if (i_dp_cmd.ins_wr1) begin
                r_free_head <= link_a;
                if (!use_pred) begin
                    r_list_head <= LW'(r_taken);
                end
            end
            if (i_dp_cmd.cap_in) begin
                r_tie_cnt <= '0;
            end
            if (i_dp_cmd.walk_start) begin
                r_cur   <= r_list_head;
                r_steps <= '0;
                r_first <= 1'b1;
            end
            if (i_dp_cmd.walk_ev) begin
                r_cur   <= link_a;
                r_steps <= r_steps + LW'(1);
                r_first <= 1'b0;
                if (r_first || (r_rd_grade < r_min)) begin
                    // new minimum restarts the tie stack
                    r_min     <= r_rd_grade;
                    r_tie_cnt <= TIE_CW'(1);
                end else if ((r_rd_grade == r_min) && (r_tie_cnt < TIE_CW'(TIE_DEPTH))) begin
                    r_tie_cnt <= r_tie_cnt + TIE_CW'(1);
                end
            end
            if (i_dp_cmd.emit_tie) begin
                r_tie_cnt <= tie_top;
            end
        end
    end

    // Tie stack writes
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.walk_ev) begin
            if (r_first || (r_rd_grade < r_min)) begin
                tie_mem[0] <= r_rd_id;
            end else if ((r_rd_grade == r_min) && (r_tie_cnt < TIE_CW'(TIE_DEPTH))) begin
                tie_mem[r_tie_cnt[TIE_IW-1:0]] <= r_rd_id;
            end
        end
    end

    // Result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_dp_cmd.emit_ins | i_dp_cmd.emit_full
                     | i_dp_cmd.emit_empty | i_dp_cmd.emit_tie;
        end
    end

    always_ff @(posedge i_clk) begin
        r_list_empty <= list_is_empty;
        r_pool_full  <= pool_is_full;
        r_slot       <= '0;
        r_out_id     <= '0;
        r_out_grade  <= '0;
        r_last       <= 1'b1;
        r_status     <= ST_EMPTY;
        if (i_dp_cmd.emit_ins) begin
            r_status <= ST_INSERTED;
            r_slot   <= taken_ext[SLOT_W-1:0];
        end else if (i_dp_cmd.emit_full) begin
            r_status <= ST_POOL_FULL;
        end else if (i_dp_cmd.emit_tie) begin
            r_status    <= ST_MIN_ENTRY;
            r_out_id    <= tie_mem[tie_top[TIE_IW-1:0]];
            r_out_grade <= r_min;
            r_last      <= (r_tie_cnt == TIE_CW'(1));
        end
    end

    assign o_sts.pool_full  = pool_is_full;
    assign o_sts.list_empty = list_is_empty;
    assign o_sts.use_pred   = use_pred;
    assign o_sts.walk_done  = walk_done;
    assign o_sts.tie_one    = (r_tie_cnt == TIE_CW'(1));

    assign o_valid      = r_valid;
    assign o_status     = r_status;
    assign o_slot_index = r_slot;
    assign o_min_id     = r_out_id;
    assign o_min_grade  = r_out_grade;
    assign o_last       = r_last;
    assign o_list_empty = r_list_empty;
    assign o_pool_full  = r_pool_full;

endmodule
